@@ rtl/core/lca_bl_pkg.sv @@
// shared constants for the binary-lifting common ancestor engine
// field widths, stream packing and operation codes; no dependencies
`default_nettype none

package lca_bl_pkg;

    // payload field widths
    localparam int NODE_W = 10;
    localparam int TIME_W = 11;

    // stream packing, zero filled to whole bytes
    localparam int IN_FIELDS_W  = 2 * NODE_W + 2 * TIME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((NODE_W + 7) / 8) * 8;

    // default sizing
    localparam int DEF_NODES  = 1024;
    localparam int DEF_LEVELS = 10;

    // operation codes carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/lca_binary_lifting_engine.sv @@
// lowest common ancestor engine built on binary lifting over on-chip memories
// depends on lca_bl_pkg for field widths, packing and operation codes
`default_nettype none

// Lowest-common-ancestor engine. Software walks the tree and hands each node to
// the block as a load request (tuser = load): node, parent, entry and exit
// times. Loads must come in preorder, parent before child, and the root names
// itself as its parent. A load writes the node's times and its level-0 jump
// pointer, then fills levels 1..LEVELS-1 by chasing the parent's rows already
// stored; a load returns nothing. A load of a node index of NODES or more is
// dropped. A query request (tuser = query) returns one result: the lowest
// common ancestor of the two nodes. If one node is an ancestor of the other,
// the result follows from the time check alone; otherwise the engine lifts
// the first node from the top level down, each level in three steps (jump
// read, time read, compare). These steps run in turn because of the single
// read port of the jump memory and of the time memory: every level needs the
// pointer before it can fetch that ancestor's times. One request is worked at
// a time; a finished result sits in an output register, and the next request
// is taken while it waits. The memories come up undefined and need no
// clearing: querying a node never loaded gives an arbitrary answer.
module lca_binary_lifting_engine #(
    parameter int NODES  = lca_bl_pkg::DEF_NODES,
    parameter int LEVELS = lca_bl_pkg::DEF_LEVELS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // request stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // first_node, second_node, entry_time, exit_time, zero fill
    input  wire  [lca_bl_pkg::IN_TDATA_W-1:0]  s_tdata,
    // opcode
    input  wire                                s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // ancestor_node, zero fill
    output logic [lca_bl_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int NW = lca_bl_pkg::NODE_W;
    localparam int TW = lca_bl_pkg::TIME_W;
    localparam int AW = $clog2(NODES);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // controller states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LD_RD = 4'd1;   // fetch parent chain pointer
    localparam logic [3:0] S_LD_WR = 4'd2;   // write next level of the row
    localparam logic [3:0] S_Q_TA  = 4'd3;   // first node times arrive
    localparam logic [3:0] S_Q_TB  = 4'd4;   // second node times, direct checks
    localparam logic [3:0] S_Q_JRD = 4'd5;   // read jump pointer at level
    localparam logic [3:0] S_Q_JUP = 4'd6;   // pointer arrives, fetch its times
    localparam logic [3:0] S_Q_TUP = 4'd7;   // times arrive, lift or stay
    localparam logic [3:0] S_Q_FIN = 4'd8;   // read parent of lifted node
    localparam logic [3:0] S_Q_PAR = 4'd9;   // parent arrives
    localparam logic [3:0] S_OUT   = 4'd10;  // hand result to output register

    // request fields
    logic          op;
    logic [NW-1:0] in_first;
    logic [NW-1:0] in_second;
    logic [TW-1:0] in_entry;
    logic [TW-1:0] in_exit;

    assign op        = s_tuser;
    assign in_first  = s_tdata[NW-1:0];
    assign in_second = s_tdata[2*NW-1:NW];
    assign in_entry  = s_tdata[2*NW+TW-1:2*NW];
    assign in_exit   = s_tdata[2*NW+2*TW-1:2*NW+TW];

    // memories: jump pointers per level and node, times per node
    logic [NW-1:0]   jump_mem [LEVELS][NODES];
    logic [2*TW-1:0] time_mem [NODES];

    logic [NW-1:0]   jump_rd_reg;
    logic [2*TW-1:0] time_rd_reg;

    // memory port controls
    logic            jw_en;
    logic [LW-1:0]   jw_lvl;
    logic [AW-1:0]   jw_addr;
    logic [NW-1:0]   jw_data;
    logic [LW-1:0]   jr_lvl;
    logic [AW-1:0]   jr_addr;
    logic            tw_en;
    logic [AW-1:0]   tw_addr;
    logic [2*TW-1:0] tw_data;
    logic [AW-1:0]   tr_addr;

    // controller registers
    logic [3:0]    state_reg,   state_next;
    logic [LW-1:0] lvl_reg,     lvl_next;
    logic [NW-1:0] a_reg,       a_next;       // loaded node, or node being lifted
    logic [NW-1:0] b_reg,       b_next;       // chain pointer on load, target on query
    logic [NW-1:0] up_reg,      up_next;
    logic [TW-1:0] a_ent_reg,   a_ent_next;
    logic [TW-1:0] a_ext_reg,   a_ext_next;
    logic [TW-1:0] b_ent_reg,   b_ent_next;
    logic [TW-1:0] b_ext_reg,   b_ext_next;
    logic [NW-1:0] res_reg,     res_next;
    logic          jp_ok_reg,   jp_ok_next;   // last jump read was in range
    logic          tm_ok_reg,   tm_ok_next;   // last time read was in range
    logic          m_valid_reg, m_valid_next;
    logic [NW-1:0] m_data_reg,  m_data_next;

    // read data with out-of-range nodes forced to zero
    logic [NW-1:0] jump_val;
    logic [TW-1:0] rd_ent;
    logic [TW-1:0] rd_ext;

    assign jump_val = jp_ok_reg ? jump_rd_reg : '0;
    assign rd_ent   = tm_ok_reg ? time_rd_reg[TW-1:0] : '0;
    assign rd_ext   = tm_ok_reg ? time_rd_reg[2*TW-1:TW] : '0;

    function automatic logic in_range(input logic [NW-1:0] node);
        in_range = (32'(node) < NODES);
    endfunction

    always_ff @(posedge clk)
    begin
        if (jw_en)
        begin
            jump_mem[jw_lvl][jw_addr] <= jw_data;
        end
        jump_rd_reg <= jump_mem[jr_lvl][jr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            time_mem[tw_addr] <= tw_data;
        end
        time_rd_reg <= time_mem[tr_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        up_next      = up_reg;
        a_ent_next   = a_ent_reg;
        a_ext_next   = a_ext_reg;
        b_ent_next   = b_ent_reg;
        b_ext_next   = b_ext_reg;
        res_next     = res_reg;
        jp_ok_next   = jp_ok_reg;
        tm_ok_next   = tm_ok_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        s_tready = 1'b0;
        jw_en    = 1'b0;
        jw_lvl   = '0;
        jw_addr  = AW'(a_reg);
        jw_data  = jump_val;
        jr_lvl   = lvl_reg;
        jr_addr  = AW'(a_reg);
        tw_en    = 1'b0;
        tw_addr  = AW'(in_first);
        tw_data  = {in_exit, in_entry};
        tr_addr  = AW'(b_reg);

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                tr_addr  = AW'(in_first);
                if (s_tvalid)
                begin
                    a_next = in_first;
                    b_next = in_second;
                    if (op == lca_bl_pkg::OP_LOAD)
                    begin
                        if (in_range(in_first))
                        begin
                            // times and level 0 go in at once
                            tw_en   = 1'b1;
                            jw_en   = 1'b1;
                            jw_lvl  = '0;
                            jw_addr = AW'(in_first);
                            jw_data = in_second;
                            lvl_next = LW'(1);
                            if (LEVELS > 1)
                            begin
                                state_next = S_LD_RD;
                            end
                        end
                    end
                    else
                    begin
                        tm_ok_next = in_range(in_first);
                        state_next = S_Q_TA;
                    end
                end
            end

            S_LD_RD:
            begin
                // row of the node one level-step up, at the level below
                jr_lvl     = lvl_reg - LW'(1);
                jr_addr    = AW'(b_reg);
                jp_ok_next = in_range(b_reg);
                state_next = S_LD_WR;
            end

            S_LD_WR:
            begin
                jw_en   = 1'b1;
                jw_lvl  = lvl_reg;
                jw_addr = AW'(a_reg);
                jw_data = jump_val;
                b_next  = jump_val;
                if (lvl_reg == LW'(LEVELS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_LD_RD;
                end
            end

            S_Q_TA:
            begin
                a_ent_next = rd_ent;
                a_ext_next = rd_ext;
                tr_addr    = AW'(b_reg);
                tm_ok_next = in_range(b_reg);
                state_next = S_Q_TB;
            end

            S_Q_TB:
            begin
                b_ent_next = rd_ent;
                b_ext_next = rd_ext;
                lvl_next   = LW'(LEVELS - 1);
                if (a_ent_reg <= rd_ent && a_ext_reg >= rd_ext)
                begin
                    res_next   = a_reg;
                    state_next = S_OUT;
                end
                else if (rd_ent <= a_ent_reg && rd_ext >= a_ext_reg)
                begin
                    res_next   = b_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_Q_JRD;
                end
            end

            S_Q_JRD:
            begin
                jr_lvl     = lvl_reg;
                jr_addr    = AW'(a_reg);
                jp_ok_next = in_range(a_reg);
                state_next = S_Q_JUP;
            end

            S_Q_JUP:
            begin
                up_next    = jump_val;
                tr_addr    = AW'(jump_val);
                tm_ok_next = in_range(jump_val);
                state_next = S_Q_TUP;
            end

            S_Q_TUP:
            begin
                // lift when the candidate is still not above the target
                if (!(rd_ent <= b_ent_reg && rd_ext >= b_ext_reg))
                begin
                    a_next = up_reg;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_FIN;
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_Q_JRD;
                end
            end

            S_Q_FIN:
            begin
                jr_lvl     = '0;
                jr_addr    = AW'(a_reg);
                jp_ok_next = in_range(a_reg);
                state_next = S_Q_PAR;
            end

            S_Q_PAR:
            begin
                res_next   = jump_val;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        up_reg     <= up_next;
        a_ent_reg  <= a_ent_next;
        a_ext_reg  <= a_ext_next;
        b_ent_reg  <= b_ent_next;
        b_ext_reg  <= b_ext_next;
        res_reg    <= res_next;
        jp_ok_reg  <= jp_ok_next;
        tm_ok_reg  <= tm_ok_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lca_bl_pkg::OUT_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire
